// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// They expect clk_i and rst_ni to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TKS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("token_scanner assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("token_scanner assertion failed");

`endif

// File: rtl/core/tks_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Types, codes and character constants shared by the scanner modules.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int MAX_LEXEME = 256;
  localparam int LEN_CAP_INT = ((MAX_LEXEME - 1) < 255) ? (MAX_LEXEME - 1) : 255;
  localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

  // Token queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_FRAC  = 3'd3,
    MODE_EXP   = 3'd4
  } scan_mode_e;

  typedef enum logic [3:0] {
    K_IDENT  = 4'd0,
    K_FUNC   = 4'd1,
    K_END    = 4'd2,
    K_MOD    = 4'd3,
    K_LOOP   = 4'd4,
    K_COND   = 4'd5,
    K_INT    = 4'd6,
    K_REAL   = 4'd7,
    K_PLUS   = 4'd8,
    K_MINUS  = 4'd9,
    K_MUL    = 4'd10,
    K_DIV    = 4'd11,
    K_BSLASH = 4'd12,
    K_EOS    = 4'd13
  } token_kind_e;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOI  = 1'b1;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  // Keywords packed big-endian, right-aligned.
  localparam logic [31:0] KW_FUNC = 32'h66756E63;
  localparam logic [31:0] KW_END  = 32'h00656E64;
  localparam logic [31:0] KW_MOD  = 32'h006D6F64;
  localparam logic [31:0] KW_LOOP = 32'h6C6F6F70;
  localparam logic [31:0] KW_COND = 32'h636F6E64;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  len;
    logic        trunc;
    logic        last;
  } token_t;

  // What the front hands to the queue for one accepted item.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

// File: rtl/core/tks_front.sv
// ----------------------------------------------------------------------------
// Token scanner front
// Accepts character items, keeps the scan state and forms up to two tokens.
// ----------------------------------------------------------------------------
module tks_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            action_i,
  input  logic [7:0]      char_byte_i,
  output tks_pkg::push_t  push_o
);
  import tks_pkg::*;

  scan_mode_e  mode_q, mode_d;
  logic [7:0]  len_q, len_d;
  logic [31:0] prefix_q, prefix_d;
  logic        ovf_q, ovf_d;

  logic        is_alpha, is_digit, cont, flush_v, flush_eff, start_v, sec_v;
  scan_mode_e  cont_mode;
  token_kind_e word_kind, flush_kind, start_kind;
  token_t      flush_tok, sec_tok, tok0, tok1;

  assign is_alpha = ((char_byte_i >= 8'h61) && (char_byte_i <= 8'h7A)) ||
                    ((char_byte_i >= 8'h41) && (char_byte_i <= 8'h5A)) ||
                    (char_byte_i == CH_UNDER);
  assign is_digit = (char_byte_i >= 8'h30) && (char_byte_i <= 8'h39);

  always_comb begin
    word_kind = K_IDENT;
    if (!ovf_q) begin
      if      (len_q == 8'd4 && prefix_q == KW_FUNC) word_kind = K_FUNC;
      else if (len_q == 8'd3 && prefix_q == KW_END)  word_kind = K_END;
      else if (len_q == 8'd3 && prefix_q == KW_MOD)  word_kind = K_MOD;
      else if (len_q == 8'd4 && prefix_q == KW_LOOP) word_kind = K_LOOP;
      else if (len_q == 8'd4 && prefix_q == KW_COND) word_kind = K_COND;
    end
  end

  // Whether the character extends the open token, and the mode it leads to.
  always_comb begin
    cont       = 1'b0;
    cont_mode  = mode_q;
    flush_v    = 1'b1;
    flush_kind = K_IDENT;
    case (mode_q)
      MODE_IDENT: begin
        cont       = is_alpha || is_digit;
        flush_kind = word_kind;
      end
      MODE_INT: begin
        flush_kind = K_INT;
        if (char_byte_i == CH_DOT) begin
          cont      = 1'b1;
          cont_mode = MODE_FRAC;
        end else begin
          cont = is_digit;
        end
      end
      MODE_FRAC: begin
        flush_kind = K_REAL;
        if (char_byte_i == CH_LOW_E || char_byte_i == CH_UP_E) begin
          cont      = 1'b1;
          cont_mode = MODE_EXP;
        end else begin
          cont = is_digit;
        end
      end
      MODE_EXP: begin
        flush_kind = K_REAL;
        cont       = is_digit;
      end
      default: begin
        flush_v = 1'b0;
      end
    endcase
  end

  always_comb begin
    start_v    = 1'b1;
    start_kind = K_PLUS;
    case (char_byte_i)
      CH_PLUS:   start_kind = K_PLUS;
      CH_MINUS:  start_kind = K_MINUS;
      CH_STAR:   start_kind = K_MUL;
      CH_SLASH:  start_kind = K_DIV;
      CH_BSLASH: start_kind = K_BSLASH;
      default:   start_v = 1'b0;
    endcase
  end

  // The flushed token comes first; the operator or end token follows it.
  always_comb begin
    flush_tok = '{kind: flush_kind, len: len_q, trunc: ovf_q, last: 1'b0};
    if (action_i == ACT_EOI) begin
      flush_eff = flush_v;
      sec_v     = 1'b1;
      sec_tok   = '{kind: K_EOS, len: 8'd0, trunc: 1'b0, last: 1'b1};
    end else begin
      flush_eff = flush_v && !cont;
      sec_v     = !cont && start_v;
      sec_tok   = '{kind: start_kind, len: 8'd1, trunc: 1'b0, last: 1'b1};
    end
    tok0      = flush_eff ? flush_tok : sec_tok;
    tok0.last = !(flush_eff && sec_v);
    tok1      = sec_tok;
    push_o.count = accept_i ? ({1'b0, flush_eff} + {1'b0, sec_v}) : 2'd0;
    push_o.tok0  = tok0;
    push_o.tok1  = tok1;
  end

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    prefix_d = prefix_q;
    ovf_d    = ovf_q;
    if (accept_i) begin
      if (action_i == ACT_EOI) begin
        mode_d   = MODE_IDLE;
        len_d    = 8'd0;
        prefix_d = 32'd0;
        ovf_d    = 1'b0;
      end else if (cont) begin
        mode_d = cont_mode;
        if (len_q < 8'd4) begin
          prefix_d = {prefix_q[23:0], char_byte_i};
        end
        if (len_q < LEN_CAP) begin
          len_d = len_q + 8'd1;
        end else begin
          ovf_d = 1'b1;
        end
      end else if (is_alpha || is_digit) begin
        mode_d   = is_alpha ? MODE_IDENT : MODE_INT;
        len_d    = 8'd1;
        prefix_d = {24'd0, char_byte_i};
        ovf_d    = 1'b0;
      end else begin
        mode_d   = MODE_IDLE;
        len_d    = 8'd0;
        prefix_d = 32'd0;
        ovf_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      len_q    <= 8'd0;
      prefix_q <= 32'd0;
      ovf_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      len_q    <= len_d;
      prefix_q <= prefix_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// File: rtl/core/tks_queue.sv
// ----------------------------------------------------------------------------
// Token scanner queue
// Short queue; takes up to two tokens and gives one per cycle when popped.
// ----------------------------------------------------------------------------
module tks_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tks_pkg::push_t  push_i,
  input  logic            pop_i,
  output logic            room_o,
  output logic            nonempty_o,
  output tks_pkg::token_t head_o
);
  import tks_pkg::*;

  token_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  // Room means a two-token item can always be taken.
  assign room_o     = cnt_q <= QCNT_W'(QDEPTH - 2);
  assign nonempty_o = cnt_q != '0;
  assign head_o     = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop_i);
    cnt_d    = cnt_q + QCNT_W'(push_i.count) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      mem[wr_ptr_q + QPTR_W'(1)] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/core/tks_back.sv
// ----------------------------------------------------------------------------
// Token scanner back
// Moves tokens from the queue into the output register.
// ----------------------------------------------------------------------------
module tks_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            nonempty_i,
  input  tks_pkg::token_t head_i,
  output logic            pop_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output tks_pkg::token_t tok_o
);
  import tks_pkg::*;

  logic   valid_q, valid_d;
  token_t tok_q;
  logic   load;

  assign load    = !valid_q || !out_stall_i;
  assign pop_o   = load && nonempty_i;
  assign valid_d = load ? nonempty_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tok_q <= head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign tok_o       = tok_q;

endmodule

// File: rtl/core/token_scanner.sv
// ----------------------------------------------------------------------------
// Token scanner
// Character-at-a-time lexer with a decoupled token output.
// ----------------------------------------------------------------------------
// The scanner takes one character item per cycle. An item yields zero, one
// or two tokens (a flushed word or number, then an operator or the end
// token); last marks the final token of an item. Tokens wait in a four-entry
// queue and leave through an output register at one per cycle unless held,
// so the sustained rate is one item per cycle while items yield at most one
// token, and falls to the output rate of one token per cycle otherwise.
// in_stall_o rises when the queue cannot hold a further two tokens.
module token_scanner (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [7:0]           char_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tks_pkg::token_kind_e token_kind_o,
  output logic [7:0]           lexeme_length_o,
  output logic                 truncated_o,
  output logic                 last_o
);
  import tks_pkg::*;

  push_t  push;
  token_t head, tok;
  logic   room, nonempty, pop, accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  tks_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .char_byte_i (char_byte_i),
    .push_o      (push)
  );

  tks_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .room_o     (room),
    .nonempty_o (nonempty),
    .head_o     (head)
  );

  tks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .tok_o       (tok)
  );

  assign token_kind_o    = tok.kind;
  assign lexeme_length_o = tok.len;
  assign truncated_o     = tok.trunc;
  assign last_o          = tok.last;

endmodule

// File: rtl/core/tks_checker.sv
// ----------------------------------------------------------------------------
// Token scanner checker
// Port-level assertions on the token output, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tks_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input tks_pkg::token_kind_e token_kind_o,
  input logic [7:0]           lexeme_length_o,
  input logic                 truncated_o,
  input logic                 last_o
);
  import tks_pkg::*;

  logic [13:0] out_word;
  logic        is_op;

  assign out_word = {token_kind_o, lexeme_length_o, truncated_o, last_o};
  assign is_op    = (token_kind_o == K_PLUS) || (token_kind_o == K_MINUS) ||
                    (token_kind_o == K_MUL) || (token_kind_o == K_DIV) ||
                    (token_kind_o == K_BSLASH);

  // A stalled token stays and does not change.
  `TKS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))

  // The end token is empty and always closes its item.
  `TKS_ASSERT(a_eos_form, !(out_valid_o && token_kind_o == K_EOS) || (last_o && lexeme_length_o == 8'd0 && !truncated_o))

  // Operators are single characters and always close their item.
  `TKS_ASSERT(a_op_form, !(out_valid_o && is_op) || (last_o && lexeme_length_o == 8'd1 && !truncated_o))

  // A truncated token reports the saturated length.
  `TKS_ASSERT(a_trunc_len, !(out_valid_o && truncated_o) || (lexeme_length_o == LEN_CAP))

endmodule

bind token_scanner tks_checker u_tks_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .token_kind_o    (token_kind_o),
  .lexeme_length_o (lexeme_length_o),
  .truncated_o     (truncated_o),
  .last_o          (last_o)
);
